// ----- hdl/smd_pkg.sv -----
package smd_pkg;

  localparam int LIN_MAX_W   = 17;
  localparam int QUEUE_DEPTH = 4;
  localparam int SQ_BITS     = 21;
  localparam int DIV_BITS    = 8;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_COLOR  = 2'd1;
  localparam logic [1:0] MODE_NORMAL = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef logic [LIN_MAX_W-1:0] lin_tab_t [256];

  // one classified quad as it travels from front to back
  typedef struct packed {
    logic [1:0]                      mode;
    logic [2:0][7:0]                 avg_rgb;
    logic [7:0]                      alpha;
    logic [2:0][LIN_MAX_W-1:0]       lvl;
    logic [2:0][10:0]                axis;
    logic [21:0]                     m2;
    logic                            zero;
  } smd_item_t;

  function automatic longint unsigned pow5_q30(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) p = (p * r) >> 30;
    return p;
  endfunction

  // srgb curve at h/510 in q16
  function automatic longint unsigned srgb_q16(input longint unsigned h);
    longint unsigned hh;
    longint unsigned x;
    longint unsigned r;
    longint unsigned c;
    longint unsigned x2;
    longint unsigned r2;
    longint unsigned v;
    hh = (h > 64'd510) ? 64'd510 : h;
    if (hh <= 64'd20) return (hh * 64'd6553600 + 64'd329460) / 64'd658920;
    x = ((64'd1000 * hh + 64'd28050) << 30) / 64'd538050;
    r = 64'd0;
    for (int k = 30; k >= 0; k--) begin
      c = r + (64'd1 << k);
      if (c <= (64'd1 << 30) && pow5_q30(c) <= x) r = c;
    end
    x2 = (x * x) >> 30;
    r2 = (r * r) >> 30;
    v  = (x2 * r2) >> 30;
    return (v + 64'd8192) >> 14;
  endfunction

  function automatic logic [LIN_MAX_W-1:0] to_lin(input longint unsigned q16, input int lfb);
    int sh;
    sh = 16 - lfb;
    if (sh == 0) return q16[LIN_MAX_W-1:0];
    return LIN_MAX_W'((q16 + (64'd1 << (sh - 1))) >> sh);
  endfunction

  // decode table (code c at 2c) or encode thresholds (code k at 2k-1)
  function automatic lin_tab_t build_lin_tab(input int lfb, input bit enc);
    lin_tab_t        t;
    longint unsigned h;
    for (int k = 0; k < 256; k++) begin
      if (enc) h = (k == 0) ? 64'd0 : longint'(2 * k - 1);
      else     h = longint'(2 * k);
      t[k] = to_lin(srgb_q16(h), lfb);
    end
    return t;
  endfunction

endpackage

// ----- hdl/smd_front.sv -----
module smd_front #(
  parameter int LIN_FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc_i,
  input  logic [1:0]          mode_i,
  input  logic [31:0]         px_tl_i,
  input  logic [31:0]         px_tr_i,
  input  logic [31:0]         px_bl_i,
  input  logic [31:0]         px_br_i,
  input  logic                stall_i,
  output logic                push_o,
  output smd_pkg::smd_item_t  item_o
);
  import smd_pkg::*;

  localparam int LIN_W = LIN_FRAC_BITS + 1;
  localparam lin_tab_t DEC_TAB = build_lin_tab(LIN_FRAC_BITS, 1'b0);

  logic [3:0][31:0]                  px;
  logic                              v1_r, v1_nxt;
  logic [1:0]                        mode1_r;
  logic [3:0][7:0]                   avg1_r, avg1_nxt;
  logic [2:0][10:0]                  axis1_r, axis1_nxt;
  logic [3:0][2:0][LIN_W-1:0]        dec1_r, dec1_nxt;
  logic                              v2_r, v2_nxt;
  smd_item_t                         item2_r, item2_nxt;
  logic                              adv;

  assign px  = {px_br_i, px_bl_i, px_tr_i, px_tl_i};
  assign adv = !stall_i;

  // stage 1: channel sums, signed axis sums, srgb decode lookups
  always_comb begin
    logic [9:0]  sum;
    logic [11:0] ax;
    for (int c = 0; c < 4; c++) begin
      sum = 10'(px[0][8*c+:8]) + 10'(px[1][8*c+:8]) + 10'(px[2][8*c+:8])
          + 10'(px[3][8*c+:8]);
      avg1_nxt[c] = 8'((sum + 10'd2) >> 2);
      if (c < 3) begin
        ax = {1'b0, sum, 1'b0} - 12'd1020;
        axis1_nxt[c] = ax[10:0];
      end
    end
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 3; c++) begin
        dec1_nxt[p][c] = DEC_TAB[px[p][8*c+:8]][LIN_W-1:0];
      end
    end
  end

  // stage 2: linear-light averages, squared length of the summed normal
  always_comb begin
    logic [LIN_W+1:0]   lsum;
    logic signed [21:0] sq;
    item2_nxt.mode    = mode1_r;
    item2_nxt.avg_rgb = avg1_r[2:0];
    item2_nxt.alpha   = avg1_r[3];
    item2_nxt.axis    = axis1_r;
    item2_nxt.m2      = '0;
    for (int c = 0; c < 3; c++) begin
      lsum = (LIN_W+2)'(dec1_r[0][c]) + (LIN_W+2)'(dec1_r[1][c])
           + (LIN_W+2)'(dec1_r[2][c]) + (LIN_W+2)'(dec1_r[3][c]) + (LIN_W+2)'(2);
      item2_nxt.lvl[c] = LIN_MAX_W'(lsum[LIN_W+1:2]);
      sq = $signed(axis1_r[c]) * $signed(axis1_r[c]);
      item2_nxt.m2 = item2_nxt.m2 + 22'(sq);
    end
    item2_nxt.zero = (axis1_r == '0);
  end

  assign v1_nxt = adv ? acc_i : v1_r;
  assign v2_nxt = adv ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r <= mode_i;
      avg1_r  <= avg1_nxt;
      axis1_r <= axis1_nxt;
      dec1_r  <= dec1_nxt;
      item2_r <= item2_nxt;
    end
  end

  assign push_o = v2_r && adv;
  assign item_o = item2_r;

endmodule

// ----- hdl/smd_queue.sv -----
module smd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  smd_pkg::smd_item_t  item_i,
  output logic                full_o,
  output logic                pop_o,
  output smd_pkg::smd_item_t  item_o
);
  import smd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  smd_item_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;

  // the back end never stalls, so any stored entry leaves at once
  assign pop_o  = (cnt_r != '0);
  assign full_o = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign item_o = mem[rd_ptr_r];

  assign wr_ptr_nxt = push_i ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
  assign rd_ptr_nxt = pop_o ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_o);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_ptr_r] <= item_i;
    end
  end

endmodule

// ----- hdl/smd_back.sv -----
module smd_back #(
  parameter int LIN_FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  smd_pkg::smd_item_t  item_i,
  output logic                valid_o,
  output logic [31:0]         pixel_o
);
  import smd_pkg::*;

  localparam int LIN_W = LIN_FRAC_BITS + 1;
  localparam int REM_W = 44;
  localparam int DRM_W = 30;
  localparam lin_tab_t ENC_TAB = build_lin_tab(LIN_FRAC_BITS, 1'b1);

  typedef struct packed {
    logic                  vld;
    smd_item_t             it;
    logic [REM_W-1:0]      rem;
    logic [SQ_BITS-1:0]    root;
  } sq_t;

  typedef struct packed {
    logic                        vld;
    logic [1:0]                  mode;
    logic [2:0][7:0]             avg_rgb;
    logic [7:0]                  alpha;
    logic [2:0][LIN_MAX_W-1:0]   lvl;
    logic                        zero;
    logic [SQ_BITS-1:0]          mq;
    logic [2:0][DRM_W-1:0]       rem;
    logic [2:0][7:0]             quo;
    logic [2:0]                  sat;
    logic [2:0]                  neg;
    logic [2:0][7:0]             code;
  } dv_t;

  sq_t         sq_r [SQ_BITS+1];
  dv_t         dv_r [DIV_BITS+1];
  dv_t         pr_nxt;
  logic        vo_r;
  logic [31:0] pix_r, pix_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r[0].vld <= 1'b0;
    end else begin
      sq_r[0].vld  <= valid_i;
      sq_r[0].it   <= item_i;
      sq_r[0].rem  <= REM_W'({item_i.m2, 20'd0});
      sq_r[0].root <= '0;
    end
  end

  // one root bit per stage, remainder form
  for (genvar g = 0; g < SQ_BITS; g++) begin : g_sqrt
    localparam int B = SQ_BITS - 1 - g;
    sq_t nxt;
    always_comb begin
      logic [REM_W-1:0] trial;
      nxt   = sq_r[g];
      trial = (REM_W'(sq_r[g].root) << (B + 1)) + (REM_W'(1) << (2 * B));
      if (sq_r[g].rem >= trial) begin
        nxt.rem  = sq_r[g].rem - trial;
        nxt.root = sq_r[g].root | (SQ_BITS'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[g+1].vld <= 1'b0;
      end else begin
        sq_r[g+1] <= nxt;
      end
    end
  end

  // numerator per axis, negative and saturation flags
  always_comb begin
    logic signed [30:0] n;
    sq_t s;
    s = sq_r[SQ_BITS];
    pr_nxt.vld     = s.vld;
    pr_nxt.mode    = s.it.mode;
    pr_nxt.avg_rgb = s.it.avg_rgb;
    pr_nxt.alpha   = s.it.alpha;
    pr_nxt.lvl     = s.it.lvl;
    pr_nxt.zero    = s.it.zero;
    pr_nxt.mq      = s.root;
    pr_nxt.quo     = '0;
    pr_nxt.code    = '0;
    for (int c = 0; c < 3; c++) begin
      n = $signed({3'b0, s.root, 7'b0}) + ($signed(s.it.axis[c]) * 31'sd130560);
      pr_nxt.neg[c] = n[30];
      pr_nxt.sat[c] = (n >= $signed({2'b0, s.root, 8'b0}));
      pr_nxt.rem[c] = n[30] ? '0 : n[DRM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].vld <= 1'b0;
    end else begin
      dv_r[0] <= pr_nxt;
    end
  end

  // one quotient bit and one srgb encode search bit per stage
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int B = DIV_BITS - 1 - j;
    dv_t nxt;
    always_comb begin
      logic [DRM_W-1:0] d;
      logic [7:0]       k;
      nxt = dv_r[j];
      d   = DRM_W'(dv_r[j].mq) << B;
      for (int c = 0; c < 3; c++) begin
        if (dv_r[j].rem[c] >= d) begin
          nxt.rem[c] = dv_r[j].rem[c] - d;
          nxt.quo[c] = dv_r[j].quo[c] | (8'd1 << B);
        end
        k = dv_r[j].code[c] | (8'd1 << B);
        if (ENC_TAB[k][LIN_W-1:0] <= dv_r[j].lvl[c][LIN_W-1:0]) begin
          nxt.code[c] = k;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1].vld <= 1'b0;
      end else begin
        dv_r[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    logic [2:0][7:0] rgb;
    dv_t f;
    f = dv_r[DIV_BITS];
    case (f.mode)
      MODE_COLOR: begin
        rgb = f.code;
      end
      MODE_NORMAL: begin
        if (f.zero) begin
          rgb = {8'd255, 8'd128, 8'd128};
        end else begin
          for (int c = 0; c < 3; c++) begin
            if (f.neg[c])      rgb[c] = 8'd0;
            else if (f.sat[c]) rgb[c] = 8'd255;
            else               rgb[c] = f.quo[c];
          end
        end
      end
      default: begin
        rgb = f.avg_rgb;
      end
    endcase
    pix_nxt = {f.alpha, rgb[2], rgb[1], rgb[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= dv_r[DIV_BITS].vld;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign valid_o = vo_r;
  assign pixel_o = pix_r;

endmodule

// ----- hdl/semantic_mip_downsample_core.sv -----
// 2x2 mip downsample of rgba8 quads, one quad per clock. the receiver cannot
// stall: each pixel is on out_pixel_out for exactly one cycle. busy only rises if
// the front-to-back queue fills, which the always-draining back end never lets
// happen, so start may be held high every cycle. most of the pipeline is the
// pipelined square root (one root bit per stage) and the divide/encode stages
// that follow. cfg_semantic_mode picks linear average, srgb color average or
// normal renorm; write it only while no quad is in flight.
module semantic_mip_downsample_core #(
  parameter int LIN_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // quad input, command style
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pixel_top_left,
  input  logic [31:0] in_pixel_top_right,
  input  logic [31:0] in_pixel_bottom_left,
  input  logic [31:0] in_pixel_bottom_right,
  // result strobe
  output logic        out_valid,
  output logic [31:0] out_pixel_out,
  // mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_semantic_mode
);
  import smd_pkg::*;

  logic [1:0] mode_r, mode_nxt;
  logic       acc;
  logic       q_full;
  logic       f_push;
  smd_item_t  f_item;
  logic       q_pop;
  smd_item_t  q_item;

  // register write always taken
  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? cfg_semantic_mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LINEAR;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign busy = q_full;
  assign acc  = start && !busy;

  // front: channel sums, srgb decode, normal sums and squared length
  smd_front #(.LIN_FRAC_BITS(LIN_FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_i   (acc),
    .mode_i  (mode_r),
    .px_tl_i (in_pixel_top_left),
    .px_tr_i (in_pixel_top_right),
    .px_bl_i (in_pixel_bottom_left),
    .px_br_i (in_pixel_bottom_right),
    .stall_i (q_full),
    .push_o  (f_push),
    .item_o  (f_item)
  );

  // short queue decoupling front and back
  smd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (f_push),
    .item_i (f_item),
    .full_o (q_full),
    .pop_o  (q_pop),
    .item_o (q_item)
  );

  // back: square root, divide, srgb encode search, final select
  smd_back #(.LIN_FRAC_BITS(LIN_FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (q_pop),
    .item_i  (q_item),
    .valid_o (out_valid),
    .pixel_o (out_pixel_out)
  );

endmodule
